### hdl/esd_pkg.sv
// Shared types, character constants and decode helpers for the escape sequence decoder.
package esd_pkg;

    // Default number of decoded-command slots between the front and back parts.
    localparam int ESD_QUEUE_DEPTH = 4;

    // Source characters with a special meaning.
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [7:0] CHAR_TAB       = 8'h09;
    localparam logic [7:0] CHAR_FORMFEED  = 8'h0C;
    localparam logic [7:0] CHAR_RETURN    = 8'h0D;
    localparam logic [7:0] BACKSPACE_CODE = 8'h08;
    localparam logic [7:0] ESC_CODE       = 8'h1B;
    localparam logic [7:0] WILDCARD_BIT   = 8'h80;

    // An octal escape holds at most three digits.
    localparam logic [1:0] MAX_OCTAL_DIGITS = 2'd3;

    // Decoder mode.
    typedef enum logic [1:0] {
        MODE_NORMAL   = 2'd0,
        MODE_ESCAPE   = 2'd1,
        MODE_OCTAL    = 2'd2,
        MODE_CONTINUE = 2'd3
    } esd_mode_t;

    // One input transaction.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_input;
    } esd_in_t;

    // One result transaction.
    typedef struct packed {
        logic [8:0] char_value;
        logic       escaped;
        logic [1:0] line_advance;
        logic       is_eof;
        logic       last;
    } esd_out_t;

    // Work handed from the front to the back: one or two results.
    typedef struct packed {
        logic     two_results;
        esd_out_t first;
        esd_out_t second;
    } esd_cmd_t;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } esd_qstat_t;

    // True for the ASCII digits 0 through 7.
    function automatic logic is_octal_digit(input logic [7:0] b);
        return b[7:3] == 5'b00110;
    endfunction

    // Character produced by a backslash followed by a byte that is neither
    // a newline nor an octal digit.
    function automatic logic [8:0] escape_map(input logic [7:0] b);
        logic [7:0] ch;
        ch = b;
        case (b)
            8'h66:             ch = CHAR_FORMFEED;   // f
            8'h72:             ch = CHAR_RETURN;     // r
            8'h74:             ch = CHAR_TAB;        // t
            8'h6E:             ch = CHAR_NEWLINE;    // n
            8'h62:             ch = BACKSPACE_CODE;  // b
            8'h65:             ch = ESC_CODE;        // e
            8'h3F, 8'h5B, 8'h2A: ch = b | WILDCARD_BIT; // ? [ *
            default:           ch = b;
        endcase
        return {1'b0, ch};
    endfunction

endpackage

### hdl/esd_front.sv
// Front part: accepts source bytes, tracks the escape mode and builds decoded commands.
module esd_front
    import esd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  esd_in_t    s_data,
    input  esd_qstat_t q_stat,
    output logic       push,
    output esd_cmd_t   push_cmd
);

    esd_mode_t  mode_reg, mode_next;
    logic [8:0] acc_reg, acc_next;
    logic [1:0] cnt_reg, cnt_next;

    logic       accept;
    logic [7:0] b;
    logic       eof;
    logic       octal;
    logic [1:0] n_results;
    esd_out_t   res0, res1;

    // A new transaction is taken whenever the queue has room.
    assign s_ready = !q_stat.full;
    assign accept  = s_valid && s_ready;
    assign b       = s_data.data_byte;
    assign eof     = s_data.end_of_input;
    assign octal   = is_octal_digit(b);

    // Next-state logic for the mode, the octal value and the digit count.
    always_comb begin
        mode_next = mode_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        if (eof) begin
            mode_next = MODE_NORMAL;
            acc_next  = '0;
            cnt_next  = '0;
        end else begin
            case (mode_reg)
                MODE_NORMAL: begin
                    if (b == CHAR_BACKSLASH) begin
                        mode_next = MODE_ESCAPE;
                    end
                end
                MODE_ESCAPE: begin
                    mode_next = MODE_NORMAL;
                    if (b == CHAR_NEWLINE) begin
                        mode_next = MODE_CONTINUE;
                    end else if (octal) begin
                        mode_next = MODE_OCTAL;
                        acc_next  = {6'b0, b[2:0]};
                        cnt_next  = 2'd1;
                    end
                end
                MODE_OCTAL: begin
                    if (cnt_reg < MAX_OCTAL_DIGITS && octal) begin
                        acc_next = {acc_reg[5:0], b[2:0]};
                        cnt_next = cnt_reg + 2'd1;
                    end else begin
                        // The terminating byte is decoded as if fresh.
                        mode_next = (b == CHAR_BACKSLASH) ? MODE_ESCAPE : MODE_NORMAL;
                        acc_next  = '0;
                        cnt_next  = '0;
                    end
                end
                MODE_CONTINUE: begin
                    if (b != CHAR_SPACE && b != CHAR_TAB) begin
                        mode_next = MODE_NORMAL;
                    end
                end
                default: mode_next = MODE_NORMAL;
            endcase
        end
    end

    // Output logic: the results that this byte produces.
    always_comb begin
        n_results = 2'd0;
        res0      = '0;
        res1      = '0;
        if (eof) begin
            // A consumed escaped newline still counts as one line.
            res0.is_eof       = 1'b1;
            res0.line_advance = (mode_reg == MODE_CONTINUE) ? 2'd1 : 2'd0;
            n_results         = 2'd1;
        end else begin
            case (mode_reg)
                MODE_NORMAL: begin
                    if (b != CHAR_BACKSLASH) begin
                        res0.char_value = {1'b0, b};
                        n_results       = 2'd1;
                    end
                end
                MODE_ESCAPE: begin
                    if (b != CHAR_NEWLINE && !octal) begin
                        res0.char_value = escape_map(b);
                        res0.escaped    = 1'b1;
                        n_results       = 2'd1;
                    end
                end
                MODE_OCTAL: begin
                    if (!(cnt_reg < MAX_OCTAL_DIGITS && octal)) begin
                        res0.char_value = acc_reg;
                        res0.escaped    = 1'b1;
                        n_results       = 2'd1;
                        if (b != CHAR_BACKSLASH) begin
                            res1.char_value = {1'b0, b};
                            n_results       = 2'd2;
                        end
                    end
                end
                MODE_CONTINUE: begin
                    if (b != CHAR_SPACE && b != CHAR_TAB) begin
                        res0.char_value   = {1'b0, b};
                        res0.escaped      = 1'b1;
                        res0.line_advance = (b == CHAR_NEWLINE) ? 2'd2 : 2'd1;
                        n_results         = 2'd1;
                    end
                end
                default: n_results = 2'd0;
            endcase
        end
        // Mark the final result of this transaction.
        if (n_results == 2'd1) begin
            res0.last = 1'b1;
        end
        if (n_results == 2'd2) begin
            res1.last = 1'b1;
        end
    end

    // Only bytes that produce something go into the queue.
    assign push                 = accept && (n_results != 2'd0);
    assign push_cmd.two_results = (n_results == 2'd2);
    assign push_cmd.first       = res0;
    assign push_cmd.second      = res1;

    // Decoder state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_NORMAL;
            acc_reg  <= '0;
            cnt_reg  <= '0;
        end else if (accept) begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

### hdl/esd_queue.sv
// Command queue that decouples the decoding front from the result back.
module esd_queue
    import esd_pkg::*;
#(
    parameter int DEPTH = ESD_QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  esd_cmd_t   push_cmd,
    input  logic       pop,
    output esd_cmd_t   pop_cmd,
    output esd_qstat_t q_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    esd_cmd_t           mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign q_stat.full  = (count_reg == CNT_W'(DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign pop_cmd      = mem_reg[rd_ptr_reg];

    // Pointer and fill-count updates, with wrap at the queue depth.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage for queued commands.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

`ifndef ASSERT_OFF
    // The front never writes into a full queue.
    assert property (@(posedge aclk) disable iff (!aresetn) push |-> !q_stat.full)
        else $error("command pushed into a full queue");
    // The back never reads from an empty queue.
    assert property (@(posedge aclk) disable iff (!aresetn) pop |-> !q_stat.empty)
        else $error("command popped from an empty queue");
`endif

endmodule

### hdl/esd_back.sv
// Back part: unpacks queued commands into one or two result transactions.
module esd_back
    import esd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  esd_qstat_t q_stat,
    input  esd_cmd_t   pop_cmd,
    output logic       pop,
    output logic       m_valid,
    input  logic       m_ready,
    output esd_out_t   m_data
);

    logic     m_valid_reg, m_valid_next;
    esd_out_t m_data_reg, m_data_next;
    logic     pend_reg, pend_next;
    esd_out_t second_reg, second_next;
    logic     load;

    // The output register can take a new result when empty or being drained.
    assign load    = !m_valid_reg || m_ready;
    assign pop     = load && !pend_reg && !q_stat.empty;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Result selection: a held second result goes before the next command.
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        pend_next    = pend_reg;
        second_next  = second_reg;
        if (load) begin
            if (pend_reg) begin
                m_valid_next = 1'b1;
                m_data_next  = second_reg;
                pend_next    = 1'b0;
            end else if (!q_stat.empty) begin
                m_valid_next = 1'b1;
                m_data_next  = pop_cmd.first;
                pend_next    = pop_cmd.two_results;
                second_next  = pop_cmd.second;
            end else begin
                m_valid_next = 1'b0;
            end
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            pend_reg    <= pend_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        second_reg <= second_next;
    end

`ifndef ASSERT_OFF
    // A held second result always sits behind a valid first one.
    assert property (@(posedge aclk) disable iff (!aresetn) pend_reg |-> m_valid_reg)
        else $error("second result held without a first result");
    // The first of two results never carries the last mark.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && pend_reg) |-> !m_data_reg.last)
        else $error("first of two results marked last");
    // The second result follows directly and closes the transaction.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && pend_reg && m_ready) |=> (m_valid_reg && m_data_reg.last))
        else $error("second result missing or not marked last");
`endif

endmodule

### hdl/escape_sequence_decoder.sv
// Top level of the backslash escape decoder with octal escapes.
//
// The decoder accepts one source byte per clock while the queue has room and
// delivers one result per clock while m_ready is high. Most bytes give zero
// or one result; a byte that ends an octal escape and is not itself a
// backslash gives two, sent one after the other on the result channel. A
// queue of QUEUE_DEPTH decoded commands sits between the front, which holds
// the escape mode and decodes each byte combinationally, and the back, which
// owns the output register, so input acceptance only stops when that queue
// is full. Each result is held in the queue, then in the output register.
module escape_sequence_decoder
    import esd_pkg::*;
#(
    parameter int QUEUE_DEPTH = ESD_QUEUE_DEPTH
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  esd_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output esd_out_t m_data
);

    esd_qstat_t q_stat;
    logic       push;
    logic       pop;
    esd_cmd_t   push_cmd;
    esd_cmd_t   pop_cmd;

    // Byte intake and decode.
    esd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .q_stat   (q_stat),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // Decoupling queue.
    esd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .q_stat   (q_stat)
    );

    // Result delivery.
    esd_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_stat  (q_stat),
        .pop_cmd (pop_cmd),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
